@@ rtl/core/sts_pkg.sv @@
// Shared constants, codes and types for the segment tree range-sum block.
`timescale 1ns / 1ps

package sts_pkg;

   localparam int SIZE_DEF       = 1024;
   localparam int VALUE_BITS_DEF = 32;
   localparam int SUM_BITS       = 42;
   localparam int POS_BITS       = 10;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef logic [SUM_BITS-1:0] sum_type;

   typedef struct packed {
      logic    valid;
      sum_type sum;
   } result_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_UPD   = 6'b000100,
      ST_QLO   = 6'b001000,
      ST_QHI   = 6'b010000,
      ST_QEND  = 6'b100000
   } state_type;

endpackage

@@ rtl/core/sts_if.sv @@
// Request and response channel interfaces of the segment tree range-sum block.
`timescale 1ns / 1ps

interface sts_req_if import sts_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic        [POS_BITS-1:0]   position;
   logic signed [VALUE_BITS-1:0] new_value;
   logic        [POS_BITS-1:0]   range_first;
   logic        [POS_BITS-1:0]   range_last;

   modport source (
      output valid, opcode, position, new_value, range_first, range_last,
      input  ready
   );
   modport sink (
      input  valid, opcode, position, new_value, range_first, range_last,
      output ready
   );
endinterface

interface sts_rsp_if import sts_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SUM_BITS-1:0] range_sum;

   modport source (output valid, range_sum, input ready);
   modport sink   (input valid, range_sum, output ready);
endinterface

@@ rtl/core/segment_tree_range_sum.sv @@
// Segment tree range-sum block: top level with response output register.
//
// Keeps a binary sum tree over SIZE signed elements in one node memory of
// 2*SIZE entries, 42 bits each. Leaf i sits at node SIZE+i.
// req_chan carries one item: opcode 0 writes new_value at position (positions
// at or past SIZE are dropped), opcode 1 asks for the sum from range_first
// to range_last inclusive (range_last clamps to SIZE-1, an empty range sums
// to zero). Only queries produce a response item on rsp_chan.
// An update holds req ready low while it walks toward the root, one step per
// tree level: each step writes a parent and reads the next sibling through
// the memory's single write and single read port.
// A query walks up to log2(SIZE)+1 levels, leaves included, through ST_QLO
// and ST_QHI at each level (one memory read each for the left and right edge
// of the range); then ST_QLO sees the walk end and ST_QEND hands over the
// sum. An empty range skips the walk and goes straight to ST_QEND.
// One item is in flight at a time; ready is high only when the sequencer idles.
// A finished sum sits in the output register while the receiver stalls, and
// the next item is taken meanwhile; a second sum waits in the sequencer.
// After reset the node memory is cleared one entry per cycle, all 2*SIZE
// entries (2048 at SIZE=1024), while ready stays low.
`timescale 1ns / 1ps

module segment_tree_range_sum import sts_pkg::*; #(
   parameter int SIZE       = SIZE_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_chan,
   sts_rsp_if.source rsp_chan
);

   localparam int NODE_W = $clog2(2 * SIZE);

   logic              wr_en;
   logic [NODE_W-1:0] wr_addr, rd_addr;
   sum_type           wr_data, rd_data;
   result_type        result;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   sum_type           rsp_sum_ff, rsp_sum_in;

   sts_engine #(
      .SIZE       (SIZE),
      .VALUE_BITS (VALUE_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .out_free (out_free),
      .result   (result)
   );

   sts_node_mem #(
      .DEPTH (2 * SIZE)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sum_in   = rsp_sum_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = result.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.range_sum = rsp_sum_ff;

endmodule

@@ rtl/core/sts_node_mem.sv @@
// Node store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sts_node_mem import sts_pkg::*; #(
   parameter int DEPTH = 2 * SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  sum_type                  wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output sum_type                  rd_data
);

   sum_type mem [DEPTH];
   sum_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sts_engine.sv @@
// Sequencer: clearing pass, update walk toward the root, range query walk.
`timescale 1ns / 1ps

module sts_engine import sts_pkg::*; #(
   parameter int SIZE       = SIZE_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   sts_req_if.sink                       req_chan,
   output logic                          wr_en,
   output logic [$clog2(2 * SIZE)-1:0]   wr_addr,
   output sum_type                       wr_data,
   output logic [$clog2(2 * SIZE)-1:0]   rd_addr,
   input  sum_type                       rd_data,
   input  logic                          out_free,
   output result_type                    result
);

   localparam int NODES  = 2 * SIZE;
   localparam int NODE_W = $clog2(NODES);
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int CMP_W  = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;
   localparam int EXT_W  = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;

   state_type                 state_ff, state_in;
   logic      [NODE_W-1:0]    idx_ff, idx_in;
   sum_type                   cur_ff, cur_in;
   logic      [CNT_W-1:0]     lo_ff, lo_in;
   logic      [CNT_W-1:0]     hi_ff, hi_in;
   sum_type                   acc_ff, acc_in;
   logic                      pend_ff, pend_in;

   logic      [CMP_W-1:0]     pos_ext, first_ext, last_ext, last_clamp, leaf_full;
   logic                      pos_ok, empty_range, accept;
   logic      [NODE_W-1:0]    leaf_addr, parent_addr;
   logic signed [EXT_W-1:0]   value_ext;
   sum_type                   leaf_value, parent_sum, acc_sum;
   logic      [CNT_W-1:0]     lo_start, hi_start, hi_dec;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext     = CMP_W'(req_chan.position);
   assign first_ext   = CMP_W'(req_chan.range_first);
   assign last_ext    = CMP_W'(req_chan.range_last);
   assign last_clamp  = (last_ext > CMP_W'(SIZE - 1)) ? CMP_W'(SIZE - 1) : last_ext;
   assign pos_ok      = pos_ext < CMP_W'(SIZE);
   assign empty_range = first_ext > last_clamp;
   assign leaf_full   = pos_ext + CMP_W'(SIZE);
   assign leaf_addr   = leaf_full[NODE_W-1:0];
   assign lo_start    = CNT_W'(first_ext + CMP_W'(SIZE));
   assign hi_start    = CNT_W'(last_clamp + CMP_W'(SIZE) + CMP_W'(1));

   assign value_ext  = EXT_W'(req_chan.new_value);
   assign leaf_value = value_ext[SUM_BITS-1:0];

   assign parent_addr = {1'b0, idx_ff[NODE_W-1:1]};
   assign parent_sum  = cur_ff + rd_data;
   // read issued last cycle lands in rd_data now
   assign acc_sum     = acc_ff + (pend_ff ? rd_data : '0);
   assign hi_dec      = hi_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      acc_in       = acc_sum;
      pend_in      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;
      rd_addr      = '0;
      result.valid = 1'b0;
      result.sum   = acc_sum;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + NODE_W'(1);
            if (idx_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.opcode == OP_UPDATE) begin
                  // out-of-range positions are dropped
                  if (pos_ok) begin
                     wr_en    = 1'b1;
                     wr_addr  = leaf_addr;
                     wr_data  = leaf_value;
                     rd_addr  = leaf_addr ^ NODE_W'(1);
                     cur_in   = leaf_value;
                     idx_in   = leaf_addr;
                     state_in = ST_UPD;
                  end
               end else begin
                  acc_in = '0;
                  lo_in  = lo_start;
                  hi_in  = hi_start;
                  state_in = empty_range ? ST_QEND : ST_QLO;
               end
            end
         end
         ST_UPD: begin
            // write parent, fetch the parent's sibling in the same cycle
            wr_en   = 1'b1;
            wr_addr = parent_addr;
            wr_data = parent_sum;
            rd_addr = parent_addr ^ NODE_W'(1);
            cur_in  = parent_sum;
            idx_in  = parent_addr;
            if (parent_addr == NODE_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QLO: begin
            if (lo_ff < hi_ff) begin
               if (lo_ff[0]) begin
                  rd_addr = lo_ff[NODE_W-1:0];
                  pend_in = 1'b1;
                  lo_in   = lo_ff + CNT_W'(1);
               end
               state_in = ST_QHI;
            end else begin
               state_in = ST_QEND;
            end
         end
         ST_QHI: begin
            lo_in = lo_ff >> 1;
            if (hi_ff[0]) begin
               rd_addr = hi_dec[NODE_W-1:0];
               pend_in = 1'b1;
               hi_in   = hi_dec >> 1;
            end else begin
               hi_in   = hi_ff >> 1;
            end
            state_in = ST_QLO;
         end
         ST_QEND: begin
            result.valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      acc_ff <= acc_in;
   end

endmodule

@@ rtl/core/sts_checker.sv @@
// Port-level assertions for the segment tree range-sum block, bound to the top.
`timescale 1ns / 1ps

module sts_checker import sts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    req_opcode,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input sum_type rsp_sum
);

   // clearing pass follows reset: no item taken, no response shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("item taken or response shown right after reset");

   // a query always leaves the sequencer busy in the cycle after it is taken
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_QUERY |=> !req_ready)
      else $error("ready stayed high after a query item");

   // a response only comes out of a finished query, never from idle
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while the sequencer was idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum))
      else $error("stalled response item dropped or changed");

endmodule

bind segment_tree_range_sum sts_checker u_sts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_opcode (req_chan.opcode),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sum    (rsp_chan.range_sum)
);
